// File: sv/tlnf_pkg.sv
package tlnf_pkg;

    typedef enum logic [1:0] {
        PH_GREEN  = 2'd0,
        PH_YELLOW = 2'd1,
        PH_RED    = 2'd2
    } t_phase;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_GREEN_SECONDS  = 2'd0,
        CFG_YELLOW_SECONDS = 2'd1,
        CFG_RED_SECONDS    = 2'd2,
        CFG_LIGHT_THRESH   = 2'd3
    } t_cfg_index;

    localparam logic [2:0] LAMP_OFF    = 3'b000;
    localparam logic [2:0] LAMP_RED    = 3'b001;
    localparam logic [2:0] LAMP_YELLOW = 3'b010;
    localparam logic [2:0] LAMP_GREEN  = 3'b100;

    localparam logic [5:0] BUTTON_PERIOD_MS = 6'd50;
    localparam logic [5:0] BUTTON_TIMER_MAX = 6'd63;
    localparam logic [8:0] LIGHT_PERIOD_MS  = 9'd500;
    localparam logic [8:0] LIGHT_TIMER_MAX  = 9'd511;
    localparam logic [9:0] BLINK_PERIOD_MS  = 10'd500;
    localparam logic [9:0] BLINK_MAX        = 10'd1023;

    // phase elapsed time is kept as whole seconds plus milliseconds;
    // 262 s 143 ms is the saturation point of an 18-bit ms count
    localparam logic [9:0] MS_LAST      = 10'd999;
    localparam logic [8:0] PH_SAT_SEC   = 9'd262;
    localparam logic [9:0] PH_SAT_MS    = 10'd143;

    typedef struct packed {
        logic [7:0]  green_seconds;
        logic [7:0]  yellow_seconds;
        logic [7:0]  red_seconds;
        logic [12:0] light_threshold;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic        entry_pending;
        logic [8:0]  phase_sec;
        logic [9:0]  phase_ms;
        logic [9:0]  blink_ms;
        logic        blink_level;
        logic [5:0]  button_ms;
        logic [8:0]  light_ms;
        logic        last_button;
        logic        display_enable;
        logic        dark;
        logic [2:0]  lamp;
    } t_state;

    typedef struct packed {
        logic       night_mode;
        logic       display_on;
        logic       display_blank;
        logic [7:0] display_seconds;
        logic       display_show;
        logic       green_lamp;
        logic       yellow_lamp;
        logic       red_lamp;
    } t_result;

endpackage

// File: sv/traffic_light_with_night_flash.sv
// Traffic light controller with night flash. Each input beat is one 1 ms tick
// carrying a light sample and the raw button level; each tick yields exactly one
// output beat with the lamp drives and display controls. A tick passes through an
// input register and one level of step logic into the output register, so the
// block takes one beat per cycle while m_axis_tready lets it; the single state
// register set, updated once per tick, sets that rate. Phase durations and the
// dark threshold are written over the config channel, which is always ready.
module traffic_light_with_night_flash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] light_level, [12] button_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] red_lamp, [1] yellow_lamp, [2] green_lamp,
                                        // [3] display_show, [11:4] display_seconds,
                                        // [12] display_blank, [13] display_on,
                                        // [14] night_mode
);
    import tlnf_pkg::*;

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    t_result     n_result;
    t_result     r_result;
    logic        r_in_valid;
    logic [11:0] r_light;
    logic        r_button;
    logic        r_out_valid;
    logic        advance;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.green_seconds   <= 8'd5;
            r_cfg.yellow_seconds  <= 8'd3;
            r_cfg.red_seconds     <= 8'd5;
            r_cfg.light_threshold <= 13'd1000;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_GREEN_SECONDS:  r_cfg.green_seconds   <= i_cfg_data[7:0];
                CFG_YELLOW_SECONDS: r_cfg.yellow_seconds  <= i_cfg_data[7:0];
                CFG_RED_SECONDS:    r_cfg.red_seconds     <= i_cfg_data[7:0];
                CFG_LIGHT_THRESH:   r_cfg.light_threshold <= i_cfg_data;
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_light  <= s_axis_tdata[11:0];
            r_button <= s_axis_tdata[12];
        end
    end

    tlnf_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_light_level  (r_light),
        .i_button_level (r_button),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_GREEN;
            r_state.entry_pending  <= 1'b1;
            r_state.phase_sec      <= '0;
            r_state.phase_ms       <= '0;
            r_state.blink_ms       <= '0;
            r_state.blink_level    <= 1'b0;
            r_state.button_ms      <= '0;
            r_state.light_ms       <= '0;
            r_state.last_button    <= 1'b1;
            r_state.display_enable <= 1'b1;
            r_state.dark           <= 1'b0;
            r_state.lamp           <= LAMP_OFF;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_result};

    // red and green are never lit together
    a_lamp_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(r_result.red_lamp && r_result.green_lamp))
        else $error("red and green lamps both on");

    // a seconds value goes out only in day mode with the display enabled
    a_show_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_result.display_show |->
            r_result.display_on && !r_result.night_mode)
        else $error("display shown while off or at night");

    a_secs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_result.display_show |-> r_result.display_seconds == 8'd0)
        else $error("seconds nonzero without show");

    a_blank_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_result.display_blank |-> !r_result.display_on)
        else $error("blank pulse while display on");

    // a result beat rises only in the cycle after a tick was stepped
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance))
        else $error("output beat without a stepped tick");

endmodule

// File: sv/tlnf_step.sv
module tlnf_step (
    input  tlnf_pkg::t_cfg    i_cfg,
    input  tlnf_pkg::t_state  i_state,
    input  logic [11:0]       i_light_level,
    input  logic              i_button_level,
    output tlnf_pkg::t_state  o_state,
    output tlnf_pkg::t_result o_result
);
    import tlnf_pkg::*;

    t_state     s;
    logic       blank;
    logic       show;
    logic [7:0] dur;
    logic [8:0] secs_full;

    always_comb begin
        s         = i_state;
        blank     = 1'b0;
        show      = 1'b0;
        dur       = i_cfg.green_seconds;
        secs_full = '0;

        // saturating elapsed counters
        if (s.phase_sec == PH_SAT_SEC && s.phase_ms == PH_SAT_MS) begin
            s.phase_ms = s.phase_ms;
        end else if (s.phase_ms == MS_LAST) begin
            s.phase_ms  = '0;
            s.phase_sec = s.phase_sec + 9'd1;
        end else begin
            s.phase_ms = s.phase_ms + 10'd1;
        end
        if (s.blink_ms != BLINK_MAX) s.blink_ms = s.blink_ms + 10'd1;
        if (s.button_ms != BUTTON_TIMER_MAX) s.button_ms = s.button_ms + 6'd1;
        if (s.light_ms != LIGHT_TIMER_MAX) s.light_ms = s.light_ms + 9'd1;

        if (s.button_ms >= BUTTON_PERIOD_MS) begin
            s.button_ms = '0;
            if (i_button_level != s.last_button) begin
                s.last_button = i_button_level;
                // release toggles the display
                if (i_button_level) begin
                    s.display_enable = ~s.display_enable;
                    blank = ~s.display_enable;
                end
            end
        end

        if (s.light_ms >= LIGHT_PERIOD_MS) begin
            s.light_ms = '0;
            s.dark     = ({1'b0, i_light_level} < i_cfg.light_threshold);
        end

        if (s.dark) begin
            if (s.blink_ms >= BLINK_PERIOD_MS) begin
                s.blink_level = ~s.blink_level;
                s.lamp        = s.blink_level ? LAMP_YELLOW : LAMP_OFF;
                s.blink_ms    = '0;
            end
        end else begin
            case (s.phase)
                PH_YELLOW: dur = i_cfg.yellow_seconds;
                PH_RED:    dur = i_cfg.red_seconds;
                default:   dur = i_cfg.green_seconds;
            endcase

            if (s.entry_pending) begin
                s.entry_pending = 1'b0;
                s.phase_sec     = '0;
                s.phase_ms      = '0;
                case (s.phase)
                    PH_YELLOW: s.lamp = LAMP_YELLOW;
                    PH_RED:    s.lamp = LAMP_RED;
                    default:   s.lamp = LAMP_GREEN;
                endcase
            end

            // elapsed <= duration, duration being whole seconds
            if (s.display_enable && (s.phase_sec < {1'b0, dur} ||
                (s.phase_sec == {1'b0, dur} && s.phase_ms == '0))) begin
                show      = 1'b1;
                secs_full = {1'b0, dur} - s.phase_sec - {8'd0, (s.phase_ms != '0)};
            end

            if (s.phase_sec >= {1'b0, dur}) begin
                case (s.phase)
                    PH_GREEN:  s.phase = PH_YELLOW;
                    PH_YELLOW: s.phase = PH_RED;
                    PH_RED:    s.phase = PH_GREEN;
                    default:   s.phase = PH_YELLOW;
                endcase
                s.entry_pending = 1'b1;
            end
        end
    end

    assign o_state                  = s;
    assign o_result.red_lamp        = s.lamp[0];
    assign o_result.yellow_lamp     = s.lamp[1];
    assign o_result.green_lamp      = s.lamp[2];
    assign o_result.display_show    = show;
    assign o_result.display_seconds = secs_full[7:0];
    assign o_result.display_blank   = blank;
    assign o_result.display_on      = s.display_enable;
    assign o_result.night_mode      = s.dark;

endmodule
